### src/nls_pkg.sv
// Shared types, constants and helper functions for the numeric literal scanner.
`timescale 1ns / 1ps

package nls_pkg;

	localparam int MAX_TOKEN_LEN = 64;
	localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam int LEN_W = 7;
	localparam int LEN_CAP = (MAX_TOKEN_LEN > 127) ? 127 : MAX_TOKEN_LEN;

	localparam logic [1:0] KIND_INT = 2'd0;
	localparam logic [1:0] KIND_FLOAT = 2'd1;
	localparam logic [1:0] KIND_NOTNUM = 2'd2;
	localparam logic [1:0] KIND_EOF = 2'd3;

	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_OCT = 2'd1;
	localparam logic [1:0] RX_HEX = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic is_first;
		logic end_of_input;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] value;
		logic [LEN_W-1:0] length;
		logic too_long;
	} result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Digit value of a hex character, or 16 when the character is no hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] d;
		d = 5'd16;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			d = {1'b0, c[3:0]};
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			d = 5'(c - 8'h57);
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			d = 5'(c - 8'h37);
		end
		return d;
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] cnt);
		logic [15:0] w;
		w = 16'(cnt);
		return (w > 16'd127) ? LEN_W'(127) : w[LEN_W-1:0];
	endfunction

endpackage

### src/nls_accum.sv
// Digit accumulator: one multiply-add by 8, 10 or 16 with saturation.
`timescale 1ns / 1ps

module nls_accum (
	input logic [31:0] acc,
	input logic [1:0] radix,
	input logic done,
	input logic [7:0] ch,
	output logic [31:0] acc_next,
	output logic done_next
);

	logic [4:0] digit;
	logic [4:0] base;
	logic [35:0] wide;
	logic [35:0] sum;

	always_comb begin
		digit = nls_pkg::hex_val(ch);
		wide = {4'b0, acc};
		case (radix)
			nls_pkg::RX_HEX: begin
				base = 5'd16;
				sum = (wide << 4) + 36'(digit);
			end
			nls_pkg::RX_OCT: begin
				base = 5'd8;
				sum = (wide << 3) + 36'(digit);
			end
			default: begin
				base = 5'd10;
				sum = (wide << 3) + (wide << 1) + 36'(digit);
			end
		endcase
		acc_next = acc;
		done_next = done;
		if (!done) begin
			if (digit >= base) begin
				done_next = 1'b1;
			end else if (sum[35:32] != 4'd0) begin
				acc_next = 32'hFFFF_FFFF;
			end else begin
				acc_next = sum[31:0];
			end
		end
	end

endmodule

### src/nls_scan.sv
// Recognizer state register and the per-character step logic.
`timescale 1ns / 1ps

module nls_scan (
	input logic clk,
	input logic arst_n,
	input logic step,
	input nls_pkg::item_t item,
	output logic res_valid,
	output nls_pkg::result_t res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INT = 3'd1;
	localparam logic [2:0] ST_HEX = 3'd2;
	localparam logic [2:0] ST_FRAC = 3'd3;
	localparam logic [2:0] ST_EXPSIGN = 3'd4;
	localparam logic [2:0] ST_EXP = 3'd5;

	logic [2:0] state_q;
	logic [1:0] radix_q;
	logic [31:0] acc_q;
	logic done_q;
	logic [nls_pkg::CNT_W-1:0] count_q;
	logic ovf_q;

	logic [2:0] state_d;
	logic [1:0] radix_d;
	logic [31:0] acc_d;
	logic done_d;
	logic [nls_pkg::CNT_W-1:0] count_d;
	logic ovf_d;

	logic [31:0] acc_step;
	logic done_step;
	logic open;
	logic accept;
	logic [7:0] c;

	nls_accum u_accum (
		.acc(acc_q),
		.radix(radix_q),
		.done(done_q),
		.ch(item.ch),
		.acc_next(acc_step),
		.done_next(done_step)
	);

	always_comb begin
		c = item.ch;
		open = (state_q >= ST_INT) && (state_q <= ST_EXP);
		state_d = state_q;
		radix_d = radix_q;
		acc_d = acc_q;
		done_d = done_q;
		count_d = count_q;
		ovf_d = ovf_q;
		res_valid = 1'b0;
		res = '0;
		accept = 1'b1;
		if (item.end_of_input) begin
			if (open) begin
				res_valid = 1'b1;
				res.kind = nls_pkg::KIND_EOF;
				res.length = nls_pkg::sat_len(count_q);
				res.too_long = ovf_q;
			end
			state_d = ST_IDLE;
			radix_d = nls_pkg::RX_DEC;
			acc_d = '0;
			done_d = 1'b0;
			count_d = '0;
			ovf_d = 1'b0;
		end else if (item.is_first) begin
			state_d = ST_IDLE;
			radix_d = nls_pkg::RX_DEC;
			acc_d = '0;
			done_d = 1'b0;
			count_d = '0;
			ovf_d = 1'b0;
			if (nls_pkg::is_dec(c)) begin
				state_d = ST_INT;
				radix_d = (c == 8'h30) ? nls_pkg::RX_OCT : nls_pkg::RX_DEC;
				acc_d = {28'd0, c[3:0]};
				count_d = nls_pkg::CNT_W'(1);
			end else if (c == 8'h2E) begin
				state_d = ST_FRAC;
				count_d = nls_pkg::CNT_W'(1);
			end else begin
				res_valid = 1'b1;
				res.kind = nls_pkg::KIND_NOTNUM;
				res.length = nls_pkg::LEN_W'(1);
			end
		end else if (!open) begin
			state_d = ST_IDLE;
			radix_d = nls_pkg::RX_DEC;
			acc_d = '0;
			done_d = 1'b0;
			count_d = '0;
			ovf_d = 1'b0;
		end else begin
			case (state_q)
				ST_INT: begin
					if (nls_pkg::is_dec(c)) begin
						acc_d = acc_step;
						done_d = done_step;
					end else if ((c == 8'h78) || (c == 8'h58)) begin
						if ((count_q == nls_pkg::CNT_W'(1)) && (radix_q == nls_pkg::RX_OCT)) begin
							radix_d = nls_pkg::RX_HEX;
						end else begin
							done_d = 1'b1;
						end
						state_d = ST_HEX;
					end else if (c == 8'h2E) begin
						state_d = ST_FRAC;
					end else if ((c == 8'h65) || (c == 8'h45)) begin
						state_d = ST_EXPSIGN;
					end else begin
						accept = 1'b0;
					end
				end
				ST_HEX: begin
					if (nls_pkg::hex_val(c) < 5'd16) begin
						acc_d = acc_step;
						done_d = done_step;
					end else begin
						accept = 1'b0;
					end
				end
				ST_FRAC: begin
					if ((c == 8'h65) || (c == 8'h45)) begin
						state_d = ST_EXPSIGN;
					end else if (!nls_pkg::is_dec(c)) begin
						accept = 1'b0;
					end
				end
				ST_EXPSIGN: begin
					state_d = ST_EXP;
					if ((c != 8'h2D) && (c != 8'h2B) && !nls_pkg::is_dec(c)) begin
						accept = 1'b0;
					end
				end
				default: begin
					if (!nls_pkg::is_dec(c)) begin
						accept = 1'b0;
					end
				end
			endcase
			if (accept) begin
				if (count_q >= nls_pkg::CNT_W'(nls_pkg::MAX_TOKEN_LEN)) begin
					ovf_d = 1'b1;
				end else begin
					count_d = count_q + nls_pkg::CNT_W'(1);
				end
			end else begin
				res_valid = 1'b1;
				res.length = nls_pkg::sat_len(count_q);
				res.too_long = ovf_q;
				if ((state_q == ST_INT) || (state_q == ST_HEX)) begin
					res.kind = nls_pkg::KIND_INT;
					res.value = acc_q;
				end else begin
					res.kind = nls_pkg::KIND_FLOAT;
				end
				state_d = ST_IDLE;
				radix_d = nls_pkg::RX_DEC;
				acc_d = '0;
				done_d = 1'b0;
				count_d = '0;
				ovf_d = 1'b0;
			end
		end
		res_valid = res_valid && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			radix_q <= nls_pkg::RX_DEC;
			acc_q <= '0;
			done_q <= 1'b0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			radix_q <= radix_d;
			acc_q <= acc_d;
			done_q <= done_d;
			count_q <= count_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

### src/numeric_literal_scanner_unit.sv
// Top level of the numeric literal scanner: input register, scan step and result register.
`timescale 1ns / 1ps
// A result is registered when the scan step takes the request that ends its token.
// One request per cycle unless the output stalls; each step updates the recognizer state.
// A stalled result register holds its result and the input register fills behind it.
// Reset is asynchronous and active low; it empties both registers and returns the
// recognizer to idle with zero value and length.

module numeric_literal_scanner_unit (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata,   // [7:0] ch
	input logic [1:0] s_axis_tuser,   // [0] is_first, [1] end_of_input
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // [31:0] value, [38:32] length, [39] zero
	output logic [2:0] m_axis_tuser   // [1:0] kind, [2] too_long
);

	nls_pkg::item_t item_s1;
	logic vld_s1;
	nls_pkg::result_t res_s2;
	logic vld_s2;

	nls_pkg::result_t scan_res;
	logic scan_vld;
	logic out_free;
	logic advance;

	assign out_free = !vld_s2 || m_axis_tready;
	assign advance = vld_s1 && out_free;
	assign s_axis_tready = !vld_s1 || advance;

	nls_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.res_valid(scan_vld),
		.res(scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.ch <= s_axis_tdata;
			item_s1.is_first <= s_axis_tuser[0];
			item_s1.end_of_input <= s_axis_tuser[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= scan_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_vld) begin
			res_s2 <= scan_res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata = {1'b0, res_s2.length, res_s2.value};
	assign m_axis_tuser = {res_s2.too_long, res_s2.kind};

	a_value_int_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] != nls_pkg::KIND_INT) |-> m_axis_tdata[31:0] == 32'd0)
		else $error("Nonzero value on a result that is not an integer.");

	a_notnum_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == nls_pkg::KIND_NOTNUM)
		|-> (m_axis_tdata[38:32] == nls_pkg::LEN_W'(1)) && !m_axis_tuser[2])
		else $error("Not-numeric result must have length one and no overflow.");

	a_too_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2]
		|-> m_axis_tdata[38:32] == nls_pkg::LEN_W'(nls_pkg::LEN_CAP))
		else $error("Overflowed token must report the saturated length.");

	a_result_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 && !vld_s2 |=> !vld_s2)
		else $error("Result appeared without a request in the input register.");

endmodule

### verif/numeric_literal_scanner_unit_test.sv
// Self-checking testbench for the numeric literal scanner with its own scanner predictor.
`timescale 1ns / 1ps

module numeric_literal_scanner_unit_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_REQUESTS = 650;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_INT,
		SCAN_HEX,
		SCAN_FRAC,
		SCAN_EXP_SIGN,
		SCAN_EXP
	} scan_state_e;

	class literal_scoreboard;
		scan_state_e state;
		logic [1:0] rdx;
		logic [31:0] acc;
		bit acc_done;
		int unsigned count;
		bit overflow;
		nls_pkg::result_t expected_tokens[$];
		int errors;
		int requests;
		int ignored;
		int tokens_checked;
		int kind_seen[4];
		int too_long_seen;

		function new();
			go_idle();
		endfunction

		function void go_idle();
			state = SCAN_IDLE;
			rdx = nls_pkg::RX_DEC;
			acc = '0;
			acc_done = 0;
			count = 0;
			overflow = 0;
		endfunction

		function bit is_decimal(logic [7:0] c);
			return (c >= "0") && (c <= "9");
		endfunction

		function logic [4:0] digit_value(logic [7:0] c);
			if ((c >= "0") && (c <= "9")) return 5'(c - "0");
			if ((c >= "a") && (c <= "f")) return 5'(c - "a" + 10);
			if ((c >= "A") && (c <= "F")) return 5'(c - "A" + 10);
			return 5'd16;
		endfunction

		function void add_digit(logic [7:0] c);
			logic [4:0] d;
			logic [63:0] base;
			logic [63:0] v;
			base = (rdx == nls_pkg::RX_HEX) ? 64'd16 : (rdx == nls_pkg::RX_OCT) ? 64'd8 : 64'd10;
			d = digit_value(c);
			if (acc_done) return;
			if (64'(d) >= base) begin
				acc_done = 1;
				return;
			end
			v = 64'(acc) * base + 64'(d);
			acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function void expect_token(logic [1:0] k, logic [31:0] v);
			nls_pkg::result_t r;
			r.kind = k;
			r.value = v;
			r.length = nls_pkg::LEN_W'((count > 127) ? 127 : count);
			r.too_long = overflow;
			expected_tokens.push_back(r);
		endfunction

		// Returns 0 when the byte ended the token without being consumed.
		function bit take_char(logic [7:0] c, bit first, bit eoi);
			bit open;
			bit accept;
			open = (state != SCAN_IDLE);
			requests++;
			if (eoi) begin
				if (open) expect_token(nls_pkg::KIND_EOF, '0);
				else ignored++;
				go_idle();
				return 1;
			end
			if (first) begin
				go_idle();
				if (is_decimal(c)) begin
					state = SCAN_INT;
					rdx = (c == "0") ? nls_pkg::RX_OCT : nls_pkg::RX_DEC;
					acc = 32'(c - "0");
					count = 1;
				end else if (c == ".") begin
					state = SCAN_FRAC;
					count = 1;
				end else begin
					count = 1;
					expect_token(nls_pkg::KIND_NOTNUM, '0);
					go_idle();
				end
				return 1;
			end
			if (!open) begin
				ignored++;
				return 1;
			end
			accept = 1;
			case (state)
				SCAN_INT: begin
					if (is_decimal(c)) begin
						add_digit(c);
					end else if ((c == "x") || (c == "X")) begin
						if ((count == 1) && (rdx == nls_pkg::RX_OCT)) rdx = nls_pkg::RX_HEX;
						else acc_done = 1;
						state = SCAN_HEX;
					end else if (c == ".") begin
						state = SCAN_FRAC;
					end else if ((c == "e") || (c == "E")) begin
						state = SCAN_EXP_SIGN;
					end else begin
						accept = 0;
					end
				end
				SCAN_HEX: begin
					if (digit_value(c) < 5'd16) add_digit(c);
					else accept = 0;
				end
				SCAN_FRAC: begin
					if ((c == "e") || (c == "E")) state = SCAN_EXP_SIGN;
					else if (!is_decimal(c)) accept = 0;
				end
				SCAN_EXP_SIGN: begin
					state = SCAN_EXP;
					if (!((c == "-") || (c == "+") || is_decimal(c))) accept = 0;
				end
				default: begin
					if (!is_decimal(c)) accept = 0;
				end
			endcase
			if (accept) begin
				if (count >= nls_pkg::MAX_TOKEN_LEN) overflow = 1;
				else count++;
				return 1;
			end
			if ((state == SCAN_INT) || (state == SCAN_HEX)) expect_token(nls_pkg::KIND_INT, acc);
			else expect_token(nls_pkg::KIND_FLOAT, '0);
			go_idle();
			return 0;
		endfunction

		function void check_token(nls_pkg::result_t got);
			nls_pkg::result_t want;
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: kind %0d, value %0h, length %0d, too_long %0d",
					got.kind, got.value, got.length, got.too_long);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			tokens_checked++;
			kind_seen[want.kind]++;
			if (want.too_long) too_long_seen++;
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.value !== want.value) begin
				$error("value: expected %0h, actual %0h", want.value, got.value);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("length: expected %0d, actual %0d", want.length, got.length);
				errors++;
			end
			if (got.too_long !== want.too_long) begin
				$error("too_long: expected %0d, actual %0d", want.too_long, got.too_long);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int cycle_count = 0;
	byte unsigned text_buf[$];
	string terminators = " ;,)(+-*/zgG\n";
	string hex_digits = "0123456789abcdefABCDEF";
	literal_scoreboard lexer_sb = new();

	numeric_literal_scanner_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("** numeric_literal_scanner_unit: FAILED **");
		$finish;
	end

	initial begin
		nls_pkg::result_t got;
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser[1:0];
				got.too_long = m_axis_tuser[2];
				got.value = m_axis_tdata[31:0];
				got.length = m_axis_tdata[38:32];
				lexer_sb.check_token(got);
			end
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_request(input logic [7:0] c, input bit first, input bit eoi,
		output bit consumed);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= c;
		s_axis_tuser <= {eoi, first};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		consumed = lexer_sb.take_char(c, first, eoi);
	endtask

	// A byte that ends a token is presented again as the first byte of the next one.
	task automatic scan_text();
		int pos;
		bit first;
		bit consumed;
		pos = 0;
		while (pos < text_buf.size()) begin
			first = (pos == 0) || (lexer_sb.state == SCAN_IDLE) || ($urandom_range(99) < 3);
			send_request(text_buf[pos], first, 0, consumed);
			if (consumed) pos++;
		end
	endtask

	task automatic load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	function automatic void push_decimals(int n);
		repeat (n) text_buf.push_back(8'h30 + 8'($urandom_range(9)));
	endfunction

	function automatic void push_hex(int n);
		repeat (n) text_buf.push_back(hex_digits[$urandom_range(hex_digits.len() - 1)]);
	endfunction

	function automatic void push_exponent();
		int sign;
		sign = $urandom_range(3);
		text_buf.push_back($urandom_range(1) ? "e" : "E");
		if (sign == 0) text_buf.push_back("+");
		else if (sign == 1) text_buf.push_back("-");
		else if (sign == 3) text_buf.push_back(terminators[$urandom_range(terminators.len() - 1)]);
		push_decimals($urandom_range(3));
	endfunction

	function automatic void build_literal();
		int pick;
		text_buf.delete();
		pick = $urandom_range(99);
		if (pick < 28) begin
			text_buf.push_back(8'h31 + 8'($urandom_range(8)));
			push_decimals($urandom_range(11));
		end else if (pick < 40) begin
			text_buf.push_back("0");
			push_decimals($urandom_range(12));
		end else if (pick < 55) begin
			text_buf.push_back("0");
			text_buf.push_back($urandom_range(1) ? "x" : "X");
			push_hex($urandom_range(10));
		end else if (pick < 75) begin
			push_decimals($urandom_range(4));
			text_buf.push_back(".");
			push_decimals($urandom_range(5));
			if ($urandom_range(1)) push_exponent();
		end else if (pick < 84) begin
			push_decimals(1 + $urandom_range(4));
			push_exponent();
		end else if (pick < 90) begin
			push_decimals(1 + $urandom_range(3));
			text_buf.push_back($urandom_range(1) ? "x" : "X");
			push_hex($urandom_range(4));
		end else if (pick < 92) begin
			push_decimals(60 + $urandom_range(15));
		end else begin
			text_buf.push_back(".");
		end
		if ($urandom_range(99) < 85)
			text_buf.push_back(terminators[$urandom_range(terminators.len() - 1)]);
	endfunction

	initial begin
		bit consumed;
		int pick;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		src_idle_pct = 12;
		sink_stall_pct = 70;
		load_text("0XfF 079 12x3 .z");
		scan_text();
		load_text("1e");
		scan_text();
		send_request(8'h00, 0, 1, consumed);
		send_request(8'hFF, 1, 0, consumed);
		send_request("7", 0, 0, consumed);
		send_request(8'hA5, 0, 1, consumed);

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				src_idle_pct = 70;
				sink_stall_pct = 12;
			end else if (phase == 2) begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			while (lexer_sb.requests - lexer_sb.ignored < (phase + 1) * TARGET_REQUESTS / 3) begin
				build_literal();
				scan_text();
				pick = $urandom_range(99);
				if (pick < 8)
					send_request(8'($urandom), 1'($urandom_range(1)), 1, consumed);
				else if (pick < 16)
					send_request(8'($urandom), 1'($urandom_range(1)), $urandom_range(7) == 0,
						consumed);
			end
		end
		s_axis_tvalid <= 0;

		while (lexer_sb.expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d requests: %0d integers, %0d floats,",
			lexer_sb.tokens_checked, lexer_sb.requests, lexer_sb.kind_seen[nls_pkg::KIND_INT],
			lexer_sb.kind_seen[nls_pkg::KIND_FLOAT]);
		$display("%0d non-numeric starts, %0d cut off by end of stream, %0d too long.",
			lexer_sb.kind_seen[nls_pkg::KIND_NOTNUM], lexer_sb.kind_seen[nls_pkg::KIND_EOF],
			lexer_sb.too_long_seen);
		if (lexer_sb.errors == 0)
			$display("** numeric_literal_scanner_unit: PASSED **");
		else
			$display("** numeric_literal_scanner_unit: FAILED **");
		$finish;
	end

endmodule
